@@ rtl/core/bwts_pkg.sv @@
// ----------------------------------------------------------------------------
// bwts_pkg
// Types and constants shared by the wake-on-bus throttle supervisor.
// ----------------------------------------------------------------------------
package bwts_pkg;

    // Event codes carried in the cmd field
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ARM      = 3'd1;
    localparam logic [2:0] CMD_VERDICT  = 3'd2;
    localparam logic [2:0] CMD_WAKE     = 3'd3;
    localparam logic [2:0] CMD_SLEEP    = 3'd4;
    localparam logic [2:0] CMD_VOLT_OK  = 3'd5;
    localparam logic [2:0] CMD_ECU_OK   = 3'd6;

    // Confirmation verdicts; any other code counts as quiet
    localparam logic [1:0] VERD_CONFIRMED = 2'd0;
    localparam logic [1:0] VERD_STUCK     = 2'd1;

    // Arm outcomes
    localparam logic [1:0] ARM_NONE       = 2'd0;
    localparam logic [1:0] ARM_ARMED      = 2'd1;
    localparam logic [1:0] ARM_SKIP_LOW   = 2'd2;
    localparam logic [1:0] ARM_SKIP_OTHER = 2'd3;

    // Register map (index = byte address / 4)
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_FEATURE_ENABLE  = 3'd0;
    localparam logic [2:0] REG_STUCK_LIMIT     = 3'd1;
    localparam logic [2:0] REG_RECOVER_LIMIT   = 3'd2;
    localparam logic [2:0] REG_FRUITLESS_LIMIT = 3'd3;
    localparam logic [2:0] REG_COOLDOWN_TICKS  = 3'd4;

    localparam int unsigned CD_W = 20;

    typedef struct packed {
        logic [2:0] cmd;
        logic       rx_level;
        logic [1:0] verdict;
    } evt_t;

    typedef struct packed {
        logic [1:0] arm_result;
        logic       wake_allowed;
        logic       suppressed_notice;
        logic       fault_now;
        logic       cooldown_active;
        logic [7:0] fruitless_count;
    } res_t;

    typedef struct packed {
        logic            feature_enable;
        logic [7:0]      stuck_limit;
        logic [7:0]      recover_limit;
        logic [7:0]      fruitless_limit;
        logic [CD_W-1:0] cooldown_ticks;
    } cfg_t;

endpackage

@@ rtl/core/bus_wake_throttle_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// bus_wake_throttle_supervisor_top
// Wake-on-bus supervisor: stuck-low fault, wake window proofs and cooldown.
//
//   channel | direction | handshake          | payload
//   evt     | in        | evt_valid/ready    | bwts_pkg::evt_t
//   res     | out       | res_valid/ready    | bwts_pkg::res_t
//   apb     | in/out    | psel/penable/pready| 5-bit paddr, 32-bit data
//
// One event per cycle sustained while results are taken. An accepted event
// is held in the input register, is processed in a single pass and its
// result is registered in the output register when that stage can advance.
// Each event gives one result.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds the pipeline; evt_ready drops only when both stages
// are full and res_ready is low.
// ----------------------------------------------------------------------------
module bus_wake_throttle_supervisor_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         evt_valid,
    output logic                         evt_ready,
    input  bwts_pkg::evt_t               evt,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bwts_pkg::res_t               res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bwts_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    bwts_pkg::cfg_t cfg;
    bwts_pkg::evt_t evt_reg;
    logic           evt_valid_reg;
    bwts_pkg::res_t res_reg;
    bwts_pkg::res_t res_next;
    logic           res_valid_reg;
    logic           advance;

    // Stage handshake
    assign advance   = evt_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !evt_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    bwts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bwts_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .evt   (evt_reg),
        .res   (res_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_ready)
            evt_valid_reg <= evt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
            evt_reg <= evt;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

endmodule

@@ rtl/core/bwts_regs.sv @@
// ----------------------------------------------------------------------------
// bwts_regs
// APB-style configuration register bank.
// ----------------------------------------------------------------------------
module bwts_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bwts_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output bwts_pkg::cfg_t               cfg
);

    bwts_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[bwts_pkg::ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feature_enable  <= 1'b1;
            cfg_reg.stuck_limit     <= 8'd3;
            cfg_reg.recover_limit   <= 8'd2;
            cfg_reg.fruitless_limit <= 8'd3;
            cfg_reg.cooldown_ticks  <= bwts_pkg::CD_W'(3600);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bwts_pkg::REG_FEATURE_ENABLE:  cfg_reg.feature_enable  <= pwdata[0];
                bwts_pkg::REG_STUCK_LIMIT:     cfg_reg.stuck_limit     <= pwdata[7:0];
                bwts_pkg::REG_RECOVER_LIMIT:   cfg_reg.recover_limit   <= pwdata[7:0];
                bwts_pkg::REG_FRUITLESS_LIMIT: cfg_reg.fruitless_limit <= pwdata[7:0];
                bwts_pkg::REG_COOLDOWN_TICKS:
                    cfg_reg.cooldown_ticks <= pwdata[bwts_pkg::CD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            bwts_pkg::REG_FEATURE_ENABLE:  prdata = {31'd0, cfg_reg.feature_enable};
            bwts_pkg::REG_STUCK_LIMIT:     prdata = {24'd0, cfg_reg.stuck_limit};
            bwts_pkg::REG_RECOVER_LIMIT:   prdata = {24'd0, cfg_reg.recover_limit};
            bwts_pkg::REG_FRUITLESS_LIMIT: prdata = {24'd0, cfg_reg.fruitless_limit};
            bwts_pkg::REG_COOLDOWN_TICKS:
                prdata = {{(32 - bwts_pkg::CD_W){1'b0}}, cfg_reg.cooldown_ticks};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/core/bwts_core.sv @@
// ----------------------------------------------------------------------------
// bwts_core
// Supervisor state and the single-pass event update.
// ----------------------------------------------------------------------------
module bwts_core (
    input  logic            clk,
    input  logic            rst_n,
    input  bwts_pkg::cfg_t  cfg,
    input  logic            step,
    input  bwts_pkg::evt_t  evt,
    output bwts_pkg::res_t  res
);

    logic [7:0]                strike_reg,   strike_next;
    logic [7:0]                clean_reg,    clean_next;
    logic                      fault_reg,    fault_next;
    logic                      notice_reg,   notice_next;
    logic                      window_reg,   window_next;
    logic                      volt_reg,     volt_next;
    logic                      ecu_reg,      ecu_next;
    logic [7:0]                streak_reg,   streak_next;
    logic [bwts_pkg::CD_W-1:0] cd_reg,       cd_next;

    logic [7:0] clean_inc;
    logic [7:0] strike_inc;
    logic [7:0] streak_inc;
    logic       cd_busy;

    assign clean_inc  = (clean_reg  == 8'hFF) ? clean_reg  : clean_reg  + 8'd1;
    assign strike_inc = (strike_reg == 8'hFF) ? strike_reg : strike_reg + 8'd1;
    assign streak_inc = (streak_reg == 8'hFF) ? streak_reg : streak_reg + 8'd1;
    assign cd_busy    = (cd_reg != '0);

    // Next state and result for one event
    always_comb
    begin
        strike_next = strike_reg;
        clean_next  = clean_reg;
        fault_next  = fault_reg;
        notice_next = notice_reg;
        window_next = window_reg;
        volt_next   = volt_reg;
        ecu_next    = ecu_reg;
        streak_next = streak_reg;
        cd_next     = cd_reg;
        res.arm_result        = bwts_pkg::ARM_NONE;
        res.wake_allowed      = 1'b0;
        res.suppressed_notice = 1'b0;

        case (evt.cmd)
            bwts_pkg::CMD_TICK:
            begin
                if (cd_busy)
                    cd_next = cd_reg - bwts_pkg::CD_W'(1);
            end
            bwts_pkg::CMD_ARM:
            begin
                if (!cfg.feature_enable)
                    res.arm_result = bwts_pkg::ARM_SKIP_OTHER;
                else if (fault_reg)
                begin
                    // recovery reading while the fault is latched
                    res.arm_result = bwts_pkg::ARM_SKIP_OTHER;
                    if (evt.rx_level)
                    begin
                        clean_next = clean_inc;
                        if (clean_inc >= cfg.recover_limit)
                        begin
                            fault_next  = 1'b0;
                            strike_next = 8'd0;
                            clean_next  = 8'd0;
                        end
                    end
                    else
                        clean_next = 8'd0;
                end
                else if (cd_busy)
                    res.arm_result = bwts_pkg::ARM_SKIP_OTHER;
                else if (!evt.rx_level)
                    res.arm_result = bwts_pkg::ARM_SKIP_LOW;
                else
                    res.arm_result = bwts_pkg::ARM_ARMED;
            end
            bwts_pkg::CMD_VERDICT:
            begin
                if (evt.verdict == bwts_pkg::VERD_CONFIRMED)
                begin
                    strike_next = 8'd0;
                    if (cd_busy)
                    begin
                        // first suppressed wake of the episode only
                        if (!notice_reg)
                        begin
                            notice_next           = 1'b1;
                            res.suppressed_notice = 1'b1;
                        end
                    end
                    else
                    begin
                        notice_next      = 1'b0;
                        res.wake_allowed = 1'b1;
                    end
                end
                else if (evt.verdict == bwts_pkg::VERD_STUCK)
                begin
                    strike_next = strike_inc;
                    if (strike_inc >= cfg.stuck_limit && !fault_reg)
                    begin
                        fault_next = 1'b1;
                        clean_next = 8'd0;
                    end
                end
                else
                    strike_next = 8'd0;
            end
            bwts_pkg::CMD_WAKE:
            begin
                window_next = 1'b1;
                volt_next   = 1'b0;
                ecu_next    = 1'b0;
            end
            bwts_pkg::CMD_SLEEP:
            begin
                if (window_reg)
                begin
                    window_next = 1'b0;
                    if (volt_reg || ecu_reg)
                    begin
                        streak_next = 8'd0;
                        cd_next     = '0;
                    end
                    else
                    begin
                        // fruitless wake
                        streak_next = streak_inc;
                        if (streak_inc >= cfg.fruitless_limit)
                            cd_next = cfg.cooldown_ticks;
                    end
                end
            end
            bwts_pkg::CMD_VOLT_OK:
            begin
                if (streak_reg != 8'd0)
                begin
                    streak_next = 8'd0;
                    cd_next     = '0;
                end
                if (window_reg)
                    volt_next = 1'b1;
            end
            bwts_pkg::CMD_ECU_OK:
            begin
                if (streak_reg != 8'd0)
                begin
                    streak_next = 8'd0;
                    cd_next     = '0;
                end
                if (window_reg)
                    ecu_next = 1'b1;
            end
            default: ;
        endcase

        res.fault_now       = fault_next;
        res.cooldown_active = (cd_next != '0);
        res.fruitless_count = streak_next;
    end

    // State update on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_reg <= 8'd0;
            clean_reg  <= 8'd0;
            fault_reg  <= 1'b0;
            notice_reg <= 1'b0;
            window_reg <= 1'b0;
            volt_reg   <= 1'b0;
            ecu_reg    <= 1'b0;
            streak_reg <= 8'd0;
            cd_reg     <= '0;
        end
        else if (step)
        begin
            strike_reg <= strike_next;
            clean_reg  <= clean_next;
            fault_reg  <= fault_next;
            notice_reg <= notice_next;
            window_reg <= window_next;
            volt_reg   <= volt_next;
            ecu_reg    <= ecu_next;
            streak_reg <= streak_next;
            cd_reg     <= cd_next;
        end
    end

endmodule

@@ rtl/core/bwts_checker.sv @@
// ----------------------------------------------------------------------------
// bwts_checker
// Port-level checks on the supervisor's result channel.
// ----------------------------------------------------------------------------
module bwts_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input bwts_pkg::res_t res
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // An allowed wake and a suppression notice never come together
    a_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.wake_allowed && res.suppressed_notice))
        else $error("wake allowed and suppressed together");

    // Suppression only happens under a running cooldown
    a_notice_cd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.suppressed_notice |-> res.cooldown_active)
        else $error("suppression notice without cooldown");

    // Arming needs no fault and no cooldown
    a_arm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.arm_result == bwts_pkg::ARM_ARMED
            |-> !res.fault_now && !res.cooldown_active)
        else $error("armed with fault or cooldown");

endmodule

bind bus_wake_throttle_supervisor_top bwts_checker u_bwts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
